>>> rtl/iwma_pkg.sv
// shared types and constants of the i/o window map allocator
package iwma_pkg;

  localparam int unsigned WINDOW_COUNT = 1024;
  localparam int unsigned WINDOW_SHIFT = 22;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned IDX_W        = $clog2(WINDOW_COUNT);
  localparam int unsigned CNT_W        = $clog2(WINDOW_COUNT + 1);
  localparam int unsigned PAGE_W       = ADDR_W - WINDOW_SHIFT;
  localparam int unsigned NEED_W       = ADDR_W + 1 - WINDOW_SHIFT;
  localparam int unsigned CMP_W        = ADDR_W + 1;
  localparam logic [CMP_W-1:0] WIN_MASK = CMP_W'((64'd1 << WINDOW_SHIFT) - 64'd1);

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [0:0] {
    REQ_ALLOC  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SKIP     = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNMAPPED = 2'd3
  } status_t;

  typedef struct packed {
    req_t              req_type;
    logic [7:0]        owner_id;
    logic [2:0]        bar_index;
    logic [ADDR_W-1:0] bar_extent;
    logic [ADDR_W-1:0] io_address;
  } in_req_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        found_owner;
    logic [2:0]        found_bar;
    logic [ADDR_W-1:0] base_address;
    logic [ADDR_W-1:0] end_address;
    logic [ADDR_W-1:0] bar_offset;
  } out_res_t;

  // what the back end has to do with a queued item
  typedef enum logic [1:0] {
    K_DONE   = 2'd0,
    K_ALLOC  = 2'd1,
    K_LOOKUP = 2'd2
  } q_kind_t;

  // idx: first window on allocate, window on lookup
  // data: extent on allocate, address on lookup
  typedef struct packed {
    q_kind_t           kind;
    status_t           status;
    logic [7:0]        owner;
    logic [2:0]        bar;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  last;
    logic [ADDR_W-1:0] data;
  } q_ent_t;

  typedef struct packed {
    logic [7:0]       owner;
    logic [2:0]       bar;
    logic [IDX_W-1:0] base;
  } win_ent_t;

  typedef enum logic [1:0] {
    BK_RUN  = 2'b01,
    BK_FILL = 2'b10
  } bk_state_t;

endpackage

>>> rtl/iwma_front.sv
// front end: classifies items and keeps the free window count
module iwma_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  iwma_pkg::in_req_t in_req,
  output logic            push,
  output iwma_pkg::q_ent_t push_ent
);

  logic [iwma_pkg::CNT_W-1:0]  free_r, free_nxt;
  logic [iwma_pkg::CMP_W-1:0]  need_sum;
  logic [iwma_pkg::NEED_W-1:0] needed;
  logic [iwma_pkg::CNT_W-1:0]  first_cnt;
  logic [iwma_pkg::PAGE_W-1:0] page;
  logic                        unmapped;

  always_comb begin
    need_sum  = iwma_pkg::CMP_W'(in_req.bar_extent) + iwma_pkg::WIN_MASK;
    needed    = need_sum[iwma_pkg::CMP_W-1:iwma_pkg::WINDOW_SHIFT];
    first_cnt = free_r - iwma_pkg::CNT_W'(needed);
    page      = in_req.io_address[iwma_pkg::ADDR_W-1:iwma_pkg::WINDOW_SHIFT];
    // windows at or above the free count are the allocated ones
    unmapped  = (iwma_pkg::CMP_W'(page) >= iwma_pkg::CMP_W'(iwma_pkg::WINDOW_COUNT)) ||
                (iwma_pkg::CMP_W'(page) < iwma_pkg::CMP_W'(free_r));

    push_ent        = '0;
    push_ent.owner  = in_req.owner_id;
    push_ent.bar    = in_req.bar_index;
    push_ent.kind   = iwma_pkg::K_DONE;
    push_ent.status = iwma_pkg::ST_OK;
    free_nxt        = free_r;

    if (in_req.req_type == iwma_pkg::REQ_LOOKUP) begin
      if (unmapped) begin
        push_ent.status = iwma_pkg::ST_UNMAPPED;
      end else begin
        push_ent.kind = iwma_pkg::K_LOOKUP;
        push_ent.idx  = iwma_pkg::IDX_W'(page);
        push_ent.data = in_req.io_address;
      end
    end else if (in_req.bar_extent == '0) begin
      push_ent.status = iwma_pkg::ST_SKIP;
    end else if (iwma_pkg::CMP_W'(needed) > iwma_pkg::CMP_W'(free_r)) begin
      push_ent.status = iwma_pkg::ST_FULL;
    end else begin
      push_ent.kind = iwma_pkg::K_ALLOC;
      push_ent.idx  = iwma_pkg::IDX_W'(first_cnt);
      push_ent.last = iwma_pkg::IDX_W'(free_r - iwma_pkg::CNT_W'(1));
      push_ent.data = in_req.bar_extent;
      if (acc) begin
        free_nxt = first_cnt;
      end
    end
  end

  assign push = acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= iwma_pkg::CNT_W'(iwma_pkg::WINDOW_COUNT);
    end else begin
      free_r <= free_nxt;
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= iwma_pkg::CNT_W'(iwma_pkg::WINDOW_COUNT))
    else $error("free window count above table size");

  a_free_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> free_r <= $past(free_r))
    else $error("free window count grew");

  a_alloc_top: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_ent.kind == iwma_pkg::K_ALLOC) |=>
      free_r == iwma_pkg::CNT_W'($past(push_ent.idx)))
    else $error("allocated run does not end the free range");

endmodule

>>> rtl/iwma_queue.sv
// short item queue between front and back end
module iwma_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  iwma_pkg::q_ent_t push_ent,
  input  logic             pop,
  output iwma_pkg::q_ent_t head_ent,
  output logic             empty,
  output logic             full
);

  iwma_pkg::q_ent_t            q_mem_r [iwma_pkg::Q_DEPTH];
  logic [iwma_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [iwma_pkg::Q_CNT_W-1:0] cnt_r;

  assign head_ent = q_mem_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == iwma_pkg::Q_CNT_W'(iwma_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + iwma_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + iwma_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + iwma_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - iwma_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/iwma_back.sv
// back end: window table, run fill sequencer and result stage
module iwma_back (
  input  logic               clk,
  input  logic               rst_n,
  input  iwma_pkg::q_ent_t   head_ent,
  input  logic               empty,
  output logic               pop,
  output logic               out_strobe,
  output iwma_pkg::out_res_t out_res
);

  iwma_pkg::win_ent_t win_mem [iwma_pkg::WINDOW_COUNT];
  iwma_pkg::win_ent_t win_rd_r;

  iwma_pkg::bk_state_t         state_r, state_nxt;
  iwma_pkg::q_ent_t            alloc_r;
  logic [iwma_pkg::IDX_W-1:0]  fill_r;
  logic                        fill_done;
  logic                        s1_vld_r, s1_vld_nxt;
  iwma_pkg::q_ent_t            s1_ent_r;
  logic                        out_strobe_r;
  iwma_pkg::out_res_t          out_res_r, res_nxt;
  logic [iwma_pkg::ADDR_W-1:0] lk_base, al_start;

  assign pop       = !empty && (state_r == iwma_pkg::BK_RUN);
  assign fill_done = (state_r == iwma_pkg::BK_FILL) && (fill_r == alloc_r.last);

  always_comb begin
    state_nxt  = state_r;
    s1_vld_nxt = 1'b0;
    case (state_r)
      iwma_pkg::BK_RUN: begin
        if (pop) begin
          if (head_ent.kind == iwma_pkg::K_ALLOC) begin
            state_nxt = iwma_pkg::BK_FILL;
          end else begin
            s1_vld_nxt = 1'b1;
          end
        end
      end
      iwma_pkg::BK_FILL: begin
        if (fill_done) begin
          state_nxt  = iwma_pkg::BK_RUN;
          s1_vld_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = iwma_pkg::BK_RUN;
      end
    endcase
  end

  // window table: one write per fill cycle, registered read at the queue head
  always_ff @(posedge clk) begin
    if (state_r == iwma_pkg::BK_FILL) begin
      win_mem[fill_r] <= '{owner: alloc_r.owner, bar: alloc_r.bar, base: alloc_r.idx};
    end
    win_rd_r <= win_mem[head_ent.idx];
  end

  always_comb begin
    lk_base  = iwma_pkg::ADDR_W'(win_rd_r.base) << iwma_pkg::WINDOW_SHIFT;
    al_start = iwma_pkg::ADDR_W'(s1_ent_r.idx) << iwma_pkg::WINDOW_SHIFT;
    res_nxt  = '0;
    case (s1_ent_r.kind)
      iwma_pkg::K_LOOKUP: begin
        res_nxt.status       = iwma_pkg::ST_OK;
        res_nxt.found_owner  = win_rd_r.owner;
        res_nxt.found_bar    = win_rd_r.bar;
        res_nxt.base_address = lk_base;
        res_nxt.bar_offset   = s1_ent_r.data - lk_base;
      end
      iwma_pkg::K_ALLOC: begin
        res_nxt.status       = iwma_pkg::ST_OK;
        res_nxt.base_address = al_start;
        res_nxt.end_address  = al_start + s1_ent_r.data;
      end
      default: begin
        res_nxt.status = s1_ent_r.status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && head_ent.kind == iwma_pkg::K_ALLOC) begin
      alloc_r <= head_ent;
      fill_r  <= head_ent.idx;
    end else if (state_r == iwma_pkg::BK_FILL && !fill_done) begin
      fill_r <= fill_r + iwma_pkg::IDX_W'(1);
    end
    if (fill_done) begin
      s1_ent_r <= alloc_r;
    end else if (pop) begin
      s1_ent_r <= head_ent;
    end
    out_res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= iwma_pkg::BK_RUN;
      s1_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      s1_vld_r     <= s1_vld_nxt;
      out_strobe_r <= s1_vld_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iwma_pkg::BK_FILL) |-> (fill_r >= alloc_r.idx && fill_r <= alloc_r.last))
    else $error("fill pointer outside the allocated run");

  a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_ent.kind != iwma_pkg::K_ALLOC) |=> s1_vld_r)
    else $error("popped item produced no result");

  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r == iwma_pkg::BK_FILL) |-> s1_vld_r && s1_ent_r.kind == iwma_pkg::K_ALLOC)
    else $error("finished fill produced no allocate result");

endmodule

>>> rtl/io_window_map_allocator_unit.sv
// top level of the i/o window map allocator
//
// maps the 32-bit i/o space in windows of 2^WINDOW_SHIFT bytes (4 MB), WINDOW_COUNT
// of them. an item is transferred on a rising edge with start high and busy low.
// req_type allocate claims ceil(extent / window) windows top-down from the highest
// free one; req_type lookup translates io_address into owner, bar, base and offset.
// every item gives exactly one result: out_strobe is high for one cycle with
// out_res valid, and the receiver cannot hold it off.
// with the back end idle, a lookup or an item that changes nothing passes the queue,
// the s1 stage and the result register before out_strobe; an allocation of n windows
// writes one table entry per cycle and shows its result once the last one is written.
// lookups sustain one item per cycle while no allocation is filling; the window
// table's single write port sets the allocation rate. a four-entry queue sits
// between the classifying front end and the back end; busy is high while it is full.
// reset empties the queue and frees every window; no clearing pass is needed,
// since the mapped windows are exactly those at or above the free count.
module io_window_map_allocator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  iwma_pkg::in_req_t  in_req,
  output logic               out_strobe,
  output iwma_pkg::out_res_t out_res
);

  logic             acc;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  iwma_pkg::q_ent_t push_ent;
  iwma_pkg::q_ent_t head_ent;

  assign busy = q_full;
  assign acc  = start && !q_full;

  iwma_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_req   (in_req),
    .push     (push),
    .push_ent (push_ent)
  );

  iwma_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head_ent (head_ent),
    .empty    (q_empty),
    .full     (q_full)
  );

  iwma_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_ent   (head_ent),
    .empty      (q_empty),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

>>> bench/io_window_map_allocator_unit_tb.sv
// self-checking bench for the i/o window map allocator: queued stimulus, window table model
`timescale 1ns / 1ps

module io_window_map_allocator_unit_tb;

  localparam int unsigned STALL_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  iwma_pkg::in_req_t  in_req = '0;
  logic               out_strobe;
  iwma_pkg::out_res_t out_res;

  io_window_map_allocator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

  // window table as the bench sees it
  bit                         win_used  [iwma_pkg::WINDOW_COUNT];
  logic [7:0]                 win_owner [iwma_pkg::WINDOW_COUNT];
  logic [2:0]                 win_bar   [iwma_pkg::WINDOW_COUNT];
  logic [iwma_pkg::IDX_W-1:0] win_base  [iwma_pkg::WINDOW_COUNT];
  int                         free_left = int'(iwma_pkg::WINDOW_COUNT);

  iwma_pkg::in_req_t  req_backlog[$];
  iwma_pkg::out_res_t due_results[$];
  logic     last_xfer = 1'b0;
  logic     calm = 1'b0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic iwma_pkg::out_res_t map_window_request(iwma_pkg::in_req_t r);
    iwma_pkg::out_res_t        res;
    logic [iwma_pkg::ADDR_W:0] rounded;
    int                        needed;
    int                        first;
    int                        w;
    int                        page;
    res = '0;
    if (r.req_type == iwma_pkg::REQ_ALLOC) begin
      if (r.bar_extent == '0) begin
        res.status = iwma_pkg::ST_SKIP;
      end else begin
        rounded = {1'b0, r.bar_extent} + iwma_pkg::WIN_MASK;
        needed  = int'(rounded >> iwma_pkg::WINDOW_SHIFT);
        if (needed > free_left) begin
          res.status = iwma_pkg::ST_FULL;
        end else begin
          first = free_left - needed;
          // claimed windows run from first up to just below the old free count
          for (w = first; w < free_left; w++) begin
            win_used[w]  = 1'b1;
            win_owner[w] = r.owner_id;
            win_bar[w]   = r.bar_index;
            win_base[w]  = iwma_pkg::IDX_W'(first);
          end
          free_left = first;
          res.status       = iwma_pkg::ST_OK;
          res.base_address = iwma_pkg::ADDR_W'(first) << iwma_pkg::WINDOW_SHIFT;
          res.end_address  = res.base_address + r.bar_extent;
        end
      end
    end else begin
      page = int'(r.io_address >> iwma_pkg::WINDOW_SHIFT);
      if (page >= iwma_pkg::WINDOW_COUNT || !win_used[page]) begin
        res.status = iwma_pkg::ST_UNMAPPED;
      end else begin
        res.status       = iwma_pkg::ST_OK;
        res.found_owner  = win_owner[page];
        res.found_bar    = win_bar[page];
        res.base_address = iwma_pkg::ADDR_W'(win_base[page]) << iwma_pkg::WINDOW_SHIFT;
        res.bar_offset   = r.io_address - res.base_address;
      end
    end
    return res;
  endfunction

  function automatic iwma_pkg::in_req_t alloc_req(logic [7:0] owner, logic [2:0] bar,
                                                  logic [iwma_pkg::ADDR_W-1:0] extent);
    iwma_pkg::in_req_t r;
    r.req_type   = iwma_pkg::REQ_ALLOC;
    r.owner_id   = owner;
    r.bar_index  = bar;
    r.bar_extent = extent;
    r.io_address = $urandom;
    return r;
  endfunction

  function automatic iwma_pkg::in_req_t lookup_req(logic [iwma_pkg::ADDR_W-1:0] addr);
    iwma_pkg::in_req_t r;
    r.req_type   = iwma_pkg::REQ_LOOKUP;
    r.owner_id   = 8'($urandom_range(0, 255));
    r.bar_index  = 3'($urandom_range(0, 7));
    r.bar_extent = $urandom;
    r.io_address = addr;
    return r;
  endfunction

  // mostly a few windows, some larger runs, a few raw 32-bit extents
  function automatic logic [iwma_pkg::ADDR_W-1:0] pick_extent();
    int unsigned roll;
    int unsigned n;
    roll = $urandom_range(0, 99);
    if (roll < 6) return '0;
    if (roll >= 96) return $urandom;
    n = (roll < 86) ? $urandom_range(1, 3) : $urandom_range(4, 16);
    if ($urandom_range(0, 3) == 0) return iwma_pkg::ADDR_W'(n) << iwma_pkg::WINDOW_SHIFT;
    return (iwma_pkg::ADDR_W'(n - 1) << iwma_pkg::WINDOW_SHIFT) +
           iwma_pkg::ADDR_W'($urandom_range(1, 1 << iwma_pkg::WINDOW_SHIFT));
  endfunction

  function automatic logic [iwma_pkg::ADDR_W-1:0] pick_address();
    logic [iwma_pkg::PAGE_W-1:0]       page;
    logic [iwma_pkg::WINDOW_SHIFT-1:0] win_off;
    win_off = iwma_pkg::WINDOW_SHIFT'($urandom);
    // aim most lookups at mapped windows
    if ($urandom_range(0, 3) != 0 && free_left < iwma_pkg::WINDOW_COUNT) begin
      page = iwma_pkg::PAGE_W'($urandom_range(free_left, iwma_pkg::WINDOW_COUNT - 1));
      return {page, win_off};
    end
    return $urandom;
  endfunction

  task automatic report(string what, logic [iwma_pkg::ADDR_W-1:0] want,
                        logic [iwma_pkg::ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // sender holds off until the block has delivered everything
  task automatic wait_drained();
    @(negedge clk);
    while (req_backlog.size() != 0 || start || due_results.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !last_xfer) begin
      // hold until the transfer happens
    end else if (!calm && $urandom_range(0, 99) < 21) begin
      start <= 1'b0;
    end else if (req_backlog.size() != 0) begin
      start  <= 1'b1;
      in_req <= req_backlog.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      last_xfer <= 1'b0;
    end else begin
      last_xfer <= start && !busy;
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_res);
          mismatches++;
        end else begin
          iwma_pkg::out_res_t want;
          want = due_results.pop_front();
          report("status", 32'(want.status), 32'(out_res.status));
          report("found_owner", 32'(want.found_owner), 32'(out_res.found_owner));
          report("found_bar", 32'(want.found_bar), 32'(out_res.found_bar));
          report("base_address", want.base_address, out_res.base_address);
          report("end_address", want.end_address, out_res.end_address);
          report("bar_offset", want.bar_offset, out_res.bar_offset);
        end
      end
      if (start && !busy) due_results.push_back(map_window_request(in_req));
      if ((start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("io_window_map_allocator_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int k;
    // directed: empty table, skip, rounding, table full, big run, lookups at edges
    req_backlog.push_back(lookup_req(32'h0000_0000));
    req_backlog.push_back(lookup_req(32'hFFFF_FFFF));
    req_backlog.push_back(alloc_req(8'h5A, 3'd3, 32'h0000_0000));
    req_backlog.push_back(alloc_req(8'hFF, 3'd7, 32'h0000_0001));
    req_backlog.push_back(alloc_req(8'h00, 3'd0, 32'h0040_0000));
    req_backlog.push_back(alloc_req(8'h81, 3'd6, 32'h0040_0001));
    req_backlog.push_back(alloc_req(8'h11, 3'd1, 32'hFFFF_FFFF));
    req_backlog.push_back(alloc_req(8'h22, 3'd2, 32'h00C0_0000));
    req_backlog.push_back(lookup_req(32'hFFFF_FFFF));
    req_backlog.push_back(lookup_req(32'hFFC0_0000));
    req_backlog.push_back(lookup_req(32'hFF80_0000));
    req_backlog.push_back(lookup_req(32'hFF00_0000));
    req_backlog.push_back(lookup_req(32'hFF7F_FFFF));
    req_backlog.push_back(lookup_req(32'hFE40_0000));
    req_backlog.push_back(lookup_req(32'hFE3F_FFFF));
    req_backlog.push_back(alloc_req(8'hA5, 3'd5, 32'h2000_0000));
    req_backlog.push_back(lookup_req(32'hDE40_0000));
    req_backlog.push_back(lookup_req(32'hDE3F_FFFF));
    req_backlog.push_back(lookup_req(32'hF000_0000));
    req_backlog.push_back(alloc_req(8'h33, 3'd4, 32'hDE40_0001));
    req_backlog.push_back(lookup_req(32'hFE3F_FFFF));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < 1680; k++) begin
      if (k == 1000) wait_drained();
      calm = (k >= 400 && k < 700);
      if ($urandom_range(0, 99) < 25)
        req_backlog.push_back(alloc_req(8'($urandom_range(0, 255)),
                                        3'($urandom_range(0, 7)), pick_extent()));
      else
        req_backlog.push_back(lookup_req(pick_address()));
      while (req_backlog.size() >= 2) @(posedge clk);
    end
    calm = 1'b0;

    // fill the table exactly, then one more claim must find it full
    wait_drained();
    if (free_left > 0)
      req_backlog.push_back(alloc_req(8'hC3, 3'd1,
                                      iwma_pkg::ADDR_W'(free_left) << iwma_pkg::WINDOW_SHIFT));
    req_backlog.push_back(alloc_req(8'h3C, 3'd6, 32'h0000_0001));
    req_backlog.push_back(lookup_req(32'h0000_0000));
    for (k = 0; k < 10; k++) req_backlog.push_back(lookup_req($urandom));

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("io_window_map_allocator_unit test passed");
    end else begin
      $display("io_window_map_allocator_unit test failed");
    end
    $finish;
  end

endmodule
